@@ sv/lrukv_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukv_pkg
// shared types and constants of the lru key-value cache with ttl expiry
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_KEY_WIDTH   = 64;
    localparam int DEF_VALUE_WIDTH = 64;
    localparam int ADDR_W          = 8;
    localparam logic [4:0] CAP_RESET = 5'd16;

    localparam logic [2:0] FN_GET    = 3'd0;
    localparam logic [2:0] FN_PUT    = 3'd1;
    localparam logic [2:0] FN_REMOVE = 3'd2;
    localparam logic [2:0] FN_EXPIRE = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_ACT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] key;
        logic [63:0] data_value;
        logic [15:0] ttl_seconds;
    } cmd_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] read_value;
        logic        evicted;
        logic [4:0]  swept_count;
        logic [4:0]  occupancy;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } rsp_t;

    typedef struct packed {
        logic              key_we;
        logic              val_we;
        logic              exp_we;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       key;
        logic [63:0]       value;
        logic [31:0]       expiry;
    } wr_t;

endpackage

@@ sv/lrukv_store.sv @@
// ----------------------------------------------------------------------------
// lrukv_store
// key, value and expiry memories with one write and one registered read port
// ----------------------------------------------------------------------------
module lrukv_store #(
    parameter int ENTRIES     = lrukv_pkg::DEF_ENTRIES,
    parameter int KEY_WIDTH   = lrukv_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lrukv_pkg::DEF_VALUE_WIDTH
) (
    input  logic                         clk,
    input  lrukv_pkg::wr_t               wr,
    input  logic [$clog2(ENTRIES)-1:0]   raddr,
    output logic [KEY_WIDTH-1:0]         key_q,
    output logic [VALUE_WIDTH-1:0]       val_q,
    output logic [31:0]                  exp_q
);
    import lrukv_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [KEY_WIDTH-1:0]   key_mem [ENTRIES];
    logic [VALUE_WIDTH-1:0] val_mem [ENTRIES];
    logic [31:0]            exp_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.addr[IW-1:0]] <= wr.key[KEY_WIDTH-1:0];
        end
        if (wr.val_we)
        begin
            val_mem[wr.addr[IW-1:0]] <= wr.value[VALUE_WIDTH-1:0];
        end
        if (wr.exp_we)
        begin
            exp_mem[wr.addr[IW-1:0]] <= wr.expiry;
        end
    end

    always_ff @(posedge clk)
    begin
        key_q <= key_mem[raddr];
        val_q <= val_mem[raddr];
        exp_q <= exp_mem[raddr];
    end

endmodule

@@ sv/lrukv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrukv_ctrl
// command sequencer: scans slots one at a time through a shared compare unit,
// keeps valid, ttl and recency state, counters and the result word
// ----------------------------------------------------------------------------
module lrukv_ctrl #(
    parameter int ENTRIES     = lrukv_pkg::DEF_ENTRIES,
    parameter int KEY_WIDTH   = lrukv_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lrukv_pkg::DEF_VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lrukv_pkg::cmd_t              cmd,
    input  logic                         cfg_we,
    input  logic [4:0]                   cfg_wdata,
    output logic                         done,
    output lrukv_pkg::rsp_t              rsp,
    output lrukv_pkg::wr_t               wr,
    output logic [$clog2(ENTRIES)-1:0]   raddr,
    input  logic [KEY_WIDTH-1:0]         key_q,
    input  logic [VALUE_WIDTH-1:0]       val_q,
    input  logic [31:0]                  exp_q
);
    import lrukv_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic hit_found_reg, hit_found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic hit_exp_reg, hit_exp_next;
    logic free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic lru_found_reg, lru_found_next;
    logic [IW-1:0] lru_idx_reg, lru_idx_next;
    logic [IW-1:0] lru_rank_reg, lru_rank_next;
    logic [CW-1:0] swept_reg, swept_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] hit_cnt_reg, hit_cnt_next;
    logic [31:0] miss_cnt_reg, miss_cnt_next;
    logic [31:0] evc_cnt_reg, evc_cnt_next;
    logic [4:0]  cap_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] ttl_reg, ttl_next;
    logic [IW-1:0] rank_reg [ENTRIES];
    logic [IW-1:0] rank_next [ENTRIES];
    logic ok_reg, ok_next;
    logic ev_reg, ev_next;
    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;

    logic          drop_en, touch_en, ins_en, evict_en;
    logic [IW-1:0] drop_idx, touch_idx, slot_idx;
    logic [4:0]    cap_z;
    logic [32:0]   exp_sum;
    logic          cur_v;

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign rsp   = rsp_reg;
    assign cap_z = (cap_reg == 5'd0) ? 5'd1 : cap_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_exp_next    = hit_exp_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        lru_found_next  = lru_found_reg;
        lru_idx_next    = lru_idx_reg;
        lru_rank_next   = lru_rank_reg;
        swept_next      = swept_reg;
        occ_next        = occ_reg;
        now_next        = now_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        evc_cnt_next    = evc_cnt_reg;
        valid_next      = valid_reg;
        ttl_next        = ttl_reg;
        rank_next       = rank_reg;
        ok_next         = ok_reg;
        ev_next         = ev_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        wr              = '0;
        raddr           = idx_reg;
        drop_en         = 1'b0;
        drop_idx        = idx_reg;
        touch_en        = 1'b0;
        touch_idx       = hit_idx_reg;
        ins_en          = 1'b0;
        evict_en        = 1'b0;
        slot_idx        = free_idx_reg;
        cur_v           = valid_reg[idx_reg];
        exp_sum         = {1'b0, now_reg} + 33'(cmd_reg.ttl_seconds);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    hit_exp_next    = 1'b0;
                    free_found_next = 1'b0;
                    lru_found_next  = 1'b0;
                    swept_next      = '0;
                    ok_next         = 1'b0;
                    ev_next         = 1'b0;
                    if (cmd.func == FN_TICK && now_reg != '1)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                raddr      = idx_reg;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (cmd_reg.func == FN_TICK)
                begin
                    if (cur_v && ttl_reg[idx_reg] && now_reg > exp_q)
                    begin
                        drop_en    = 1'b1;
                        drop_idx   = idx_reg;
                        swept_next = swept_reg + CW'(1);
                        occ_next   = occ_reg - CW'(1);
                    end
                end
                else
                begin
                    if (cur_v && key_q == cmd_reg.key[KEY_WIDTH-1:0] && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = idx_reg;
                        hit_exp_next   = ttl_reg[idx_reg] && (now_reg > exp_q);
                    end
                    if (!cur_v && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (cur_v && (!lru_found_reg || rank_reg[idx_reg] > lru_rank_reg))
                    begin
                        lru_found_next = 1'b1;
                        lru_idx_next   = idx_reg;
                        lru_rank_next  = rank_reg[idx_reg];
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_ACT;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_RD;
                end
            end
            ST_ACT:
            begin
                raddr = hit_idx_reg;
                case (cmd_reg.func)
                    FN_GET:
                    begin
                        if (hit_found_reg && hit_exp_reg)
                        begin
                            drop_en       = 1'b1;
                            drop_idx      = hit_idx_reg;
                            occ_next      = occ_reg - CW'(1);
                            miss_cnt_next = miss_cnt_reg + 32'd1;
                        end
                        else if (hit_found_reg)
                        begin
                            touch_en     = 1'b1;
                            hit_cnt_next = hit_cnt_reg + 32'd1;
                            ok_next      = 1'b1;
                        end
                        else
                        begin
                            miss_cnt_next = miss_cnt_reg + 32'd1;
                        end
                    end
                    FN_PUT:
                    begin
                        if (hit_found_reg)
                        begin
                            wr.val_we             = 1'b1;
                            wr.addr               = ADDR_W'(hit_idx_reg);
                            wr.value              = cmd_reg.data_value;
                            ttl_next[hit_idx_reg] = 1'b0;
                            touch_en              = 1'b1;
                        end
                        else
                        begin
                            ins_en   = 1'b1;
                            evict_en = (32'(occ_reg) >= 32'(ENTRIES))
                                    || (32'(occ_reg) >= 32'(cap_z));
                            if (evict_en)
                            begin
                                slot_idx = (free_found_reg && free_idx_reg < lru_idx_reg)
                                         ? free_idx_reg : lru_idx_reg;
                                evc_cnt_next = evc_cnt_reg + 32'd1;
                                ev_next      = 1'b1;
                            end
                            else
                            begin
                                occ_next = occ_reg + CW'(1);
                            end
                            wr.key_we = 1'b1;
                            wr.val_we = 1'b1;
                            wr.addr   = ADDR_W'(slot_idx);
                            wr.key    = cmd_reg.key;
                            wr.value  = cmd_reg.data_value;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (hit_found_reg)
                        begin
                            drop_en  = 1'b1;
                            drop_idx = hit_idx_reg;
                            occ_next = occ_reg - CW'(1);
                            ok_next  = 1'b1;
                        end
                    end
                    FN_EXPIRE:
                    begin
                        if (hit_found_reg)
                        begin
                            ttl_next[hit_idx_reg] = 1'b1;
                            wr.exp_we = 1'b1;
                            wr.addr   = ADDR_W'(hit_idx_reg);
                            wr.expiry = exp_sum[32] ? '1 : exp_sum[31:0];
                            ok_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                rsp_next.ok             = ok_reg;
                rsp_next.read_value     = (ok_reg && cmd_reg.func == FN_GET)
                                        ? 64'(val_q) : 64'd0;
                rsp_next.evicted        = ev_reg;
                rsp_next.swept_count    = 5'(swept_reg);
                rsp_next.occupancy      = 5'(occ_reg);
                rsp_next.hit_total      = hit_cnt_reg;
                rsp_next.miss_total     = miss_cnt_reg;
                rsp_next.eviction_total = evc_cnt_reg;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        for (int j = 0; j < ENTRIES; j++)
        begin
            if (drop_en && valid_reg[j] && j != int'(drop_idx)
                && rank_reg[j] > rank_reg[drop_idx])
            begin
                rank_next[j] = rank_reg[j] - IW'(1);
            end
            if (touch_en && valid_reg[j] && j != int'(touch_idx)
                && rank_reg[j] < rank_reg[touch_idx])
            begin
                rank_next[j] = rank_reg[j] + IW'(1);
            end
            if (ins_en && valid_reg[j] && !(evict_en && j == int'(lru_idx_reg)))
            begin
                rank_next[j] = rank_reg[j] + IW'(1);
            end
        end
        if (drop_en)
        begin
            valid_next[drop_idx] = 1'b0;
            ttl_next[drop_idx]   = 1'b0;
            rank_next[drop_idx]  = '0;
        end
        if (touch_en)
        begin
            rank_next[touch_idx] = '0;
        end
        if (ins_en)
        begin
            if (evict_en)
            begin
                valid_next[lru_idx_reg] = 1'b0;
                ttl_next[lru_idx_reg]   = 1'b0;
                rank_next[lru_idx_reg]  = '0;
            end
            valid_next[slot_idx] = 1'b1;
            ttl_next[slot_idx]   = 1'b0;
            rank_next[slot_idx]  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            now_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            evc_cnt_reg  <= '0;
            cap_reg      <= CAP_RESET;
            valid_reg    <= '0;
            ttl_reg      <= '0;
            done_reg     <= 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            now_reg      <= now_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            evc_cnt_reg  <= evc_cnt_next;
            valid_reg    <= valid_next;
            ttl_reg      <= ttl_next;
            done_reg     <= done_next;
            rank_reg     <= rank_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_exp_reg    <= hit_exp_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        lru_found_reg  <= lru_found_next;
        lru_idx_reg    <= lru_idx_next;
        lru_rank_reg   <= lru_rank_next;
        swept_reg      <= swept_next;
        ok_reg         <= ok_next;
        ev_reg         <= ev_next;
        rsp_reg        <= rsp_next;
    end

`ifndef NO_ASSERTIONS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result word while sequencer busy");

    a_now_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (now_reg == $past(now_reg)))
        else $error("time moved during a command");

    a_ttl_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ttl_reg & ~valid_reg) == '0)
        else $error("ttl set on an empty slot");
`endif

endmodule

@@ sv/lru_key_value_cache_ttl_core.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_ttl_core
// fully associative key-value cache with lru replacement and per-entry ttl
// ----------------------------------------------------------------------------
//  channel   signals                  handshake
//  command   cmd                      start & !busy
//  result    rsp                      done, one cycle, no back-pressure
//  config    cfg_wdata                cfg_we, capacity register
//
//  a command scans every slot in turn through one compare unit, each slot
//  a memory read then a check, followed by an action state and a finish state
//  rst_n clears valid, ttl and recency bits, time and counters at once
//  busy stays high from accept until the result word is driven
//  the result word is shown for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
module lru_key_value_cache_ttl_core #(
    parameter int ENTRIES     = lrukv_pkg::DEF_ENTRIES,
    parameter int KEY_WIDTH   = lrukv_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lrukv_pkg::DEF_VALUE_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  lrukv_pkg::cmd_t cmd,
    input  logic            cfg_we,
    input  logic [4:0]      cfg_wdata,
    output logic            done,
    output lrukv_pkg::rsp_t rsp
);
    import lrukv_pkg::*;

    wr_t                       wr;
    logic [$clog2(ENTRIES)-1:0] raddr;
    logic [KEY_WIDTH-1:0]      key_q;
    logic [VALUE_WIDTH-1:0]    val_q;
    logic [31:0]               exp_q;

    lrukv_store #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .key_q (key_q),
        .val_q (val_q),
        .exp_q (exp_q)
    );

    lrukv_ctrl #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .rsp       (rsp),
        .wr        (wr),
        .raddr     (raddr),
        .key_q     (key_q),
        .val_q     (val_q),
        .exp_q     (exp_q)
    );

endmodule
